### src/cppt_pkg.sv
// Shared constants and default parameters for the cluster photon/pi0 tagger.
`default_nettype none
package cppt_pkg;
	localparam int DEF_ENERGY_BITS     = 24;
	localparam int DEF_POSITION_BITS   = 24;
	localparam int DEF_SCORE_FRAC_BITS = 16;
	localparam int PDG_BITS  = 7;
	localparam int MASS_BITS = 20;
	localparam logic [PDG_BITS-1:0]  CODE_PI0    = 7'd111;
	localparam logic [PDG_BITS-1:0]  CODE_PHOTON = 7'd22;
	localparam logic [MASS_BITS-1:0] MASS_RESET  = 20'd134977;
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_MASS      = 1'b1;
endpackage
`default_nettype wire

### src/cppt_isqrt.sv
// Pipelined integer square root, two radicand bits per stage.
`default_nettype none
module cppt_isqrt import cppt_pkg::*; #(
	parameter int R = DEF_POSITION_BITS + 1
) (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire logic [2*R-1:0] val,
	output logic      [R-1:0]   root
);
	logic [2*R-1:0] val_s  [0:R];
	logic [R+1:0]   rem_s  [0:R];
	logic [R-1:0]   root_s [0:R];

	always_comb begin
		val_s[0]  = val;
		rem_s[0]  = '0;
		root_s[0] = '0;
	end

	for (genvar k = 0; k < R; k++) begin : g_stage
		logic [R+3:0] cur;
		logic [R+3:0] trial;
		logic         take;
		assign cur   = {rem_s[k], val_s[k][2*R-1 -: 2]};
		assign trial = (R+4)'({root_s[k], 2'b01});
		assign take  = cur >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				val_s[k+1]  <= {val_s[k][2*R-3:0], 2'b00};
				rem_s[k+1]  <= take ? (R+2)'(cur - trial) : (R+2)'(cur);
				root_s[k+1] <= {root_s[k][R-2:0], take};
			end
		end
	end

	assign root = root_s[R];
endmodule
`default_nettype wire

### src/cppt_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module cppt_div import cppt_pkg::*; #(
	parameter int E = DEF_ENERGY_BITS,
	parameter int P = DEF_POSITION_BITS
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [E+P-1:0] num,
	input  wire logic [P:0]   den,
	output logic      [E-1:0] quo
);
	localparam int W = E + P + 1;
	logic [W-1:0] r_s [0:E];
	logic [P:0]   d_s [0:E];
	logic [E-1:0] q_s [0:E];

	always_comb begin
		r_s[0] = W'(num);
		d_s[0] = den;
		q_s[0] = '0;
	end

	for (genvar k = 0; k < E; k++) begin : g_stage
		logic [W-1:0] dsh;
		logic         take;
		assign dsh  = W'(d_s[k]) << (E - 1 - k);
		assign take = r_s[k] >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k+1] <= take ? r_s[k] - dsh : r_s[k];
				d_s[k+1] <= d_s[k];
				q_s[k+1] <= {q_s[k][E-2:0], take};
			end
		end
	end

	assign quo = q_s[E];
endmodule
`default_nettype wire

### src/cluster_photon_pi0_tagger.sv
// Cluster photon/pi0 tagger top level with momentum reconstruction pipeline.
// One transaction is accepted every cycle; a stalled output holds the whole pipeline.
// The square root runs one stage per root bit and the divider one stage per quotient bit.
// Reset clears valid bits and loads the default threshold and pi0 mass.
`default_nettype none
module cluster_photon_pi0_tagger import cppt_pkg::*; #(
	parameter int ENERGY_BITS     = DEF_ENERGY_BITS,
	parameter int POSITION_BITS   = DEF_POSITION_BITS,
	parameter int SCORE_FRAC_BITS = DEF_SCORE_FRAC_BITS
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr_en,
	input  wire logic                       wr_index,
	input  wire logic [((SCORE_FRAC_BITS+1 > MASS_BITS) ? SCORE_FRAC_BITS+1 : MASS_BITS)-1:0]
	                                        wr_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [SCORE_FRAC_BITS:0]   cluster_score,
	input  wire logic [ENERGY_BITS-1:0]     cluster_energy,
	input  wire logic [POSITION_BITS-1:0]   pos_x,
	input  wire logic [POSITION_BITS-1:0]   pos_y,
	input  wire logic [POSITION_BITS-1:0]   pos_z,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic      [PDG_BITS-1:0]        pdg_code,
	output logic      [MASS_BITS-1:0]       particle_mass,
	output logic      [SCORE_FRAC_BITS:0]   likelihood,
	output logic      [ENERGY_BITS-1:0]     energy_out,
	output logic      [ENERGY_BITS:0]       mom_x,
	output logic      [ENERGY_BITS:0]       mom_y,
	output logic      [ENERGY_BITS:0]       mom_z,
	output logic                            direction_undefined
);
	localparam int E = ENERGY_BITS;
	localparam int P = POSITION_BITS;
	localparam int S = SCORE_FRAC_BITS;
	localparam int R = P + 1;
	localparam int TW = PDG_BITS + MASS_BITS + S + 1 + E + 3 + 1;
	localparam logic [S:0] ONE = (S+1)'(1) << S;

	logic [S:0]           thr_q;
	logic [MASS_BITS-1:0] mass_q;
	logic                 en;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= (S+1)'(1) << (S - 1);
			mass_q <= MASS_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_THRESHOLD: thr_q  <= (S+1)'(wr_data);
				REG_MASS:      mass_q <= MASS_BITS'(wr_data);
				default: ;
			endcase
		end
	end

	// Stage 1: classification and sign/magnitude split.
	logic [P-1:0] pos_in [0:2];
	assign pos_in[0] = pos_x;
	assign pos_in[1] = pos_y;
	assign pos_in[2] = pos_z;

	logic                 v_s1, v_s2, v_s3;
	logic [P-1:0]         mag_s1 [0:2];
	logic [2:0]           neg_s1, neg_s2, neg_s3;
	logic [E-1:0]         en_s1, en_s2, en_s3;
	logic [PDG_BITS-1:0]  pdg_s1, pdg_s2, pdg_s3;
	logic [MASS_BITS-1:0] mass_s1, mass_s2, mass_s3;
	logic [S:0]           lik_s1, lik_s2, lik_s3;
	logic [S:0]           sat;
	logic                 is_pi0;

	assign sat    = (cluster_score > ONE) ? ONE : cluster_score;
	assign is_pi0 = cluster_score > thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= pos_in[i][P-1];
				mag_s1[i] <= pos_in[i][P-1] ? P'(-pos_in[i]) : pos_in[i];
			end
			en_s1   <= cluster_energy;
			pdg_s1  <= is_pi0 ? CODE_PI0 : CODE_PHOTON;
			mass_s1 <= is_pi0 ? mass_q : '0;
			lik_s1  <= is_pi0 ? sat : ONE - sat;
		end
	end

	// Stage 2: squares and energy products; stage 3: sum of squares and zero flag. A magnitude of exactly 2^(P-1)
	// comes out of the negation as the top bit alone, which is still correct.
	logic [2*P-1:0] sq_s2   [0:2];
	logic [E+P-1:0] prod_s2 [0:2];
	logic [E+P-1:0] prod_s3 [0:2];
	logic [2*P+1:0] sum_s3;
	logic           zero_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i]   <= mag_s1[i] * mag_s1[i];
				prod_s2[i] <= en_s1 * mag_s1[i];
				prod_s3[i] <= prod_s2[i];
			end
			neg_s2  <= neg_s1;
			en_s2   <= en_s1;
			pdg_s2  <= pdg_s1;
			mass_s2 <= mass_s1;
			lik_s2  <= lik_s1;
			sum_s3  <= (2*P+2)'(sq_s2[0]) + (2*P+2)'(sq_s2[1]) + (2*P+2)'(sq_s2[2]);
			zero_s3 <= (sq_s2[0] == '0) && (sq_s2[1] == '0) && (sq_s2[2] == '0);
			neg_s3  <= neg_s2;
			en_s3   <= en_s2;
			pdg_s3  <= pdg_s2;
			mass_s3 <= mass_s2;
			lik_s3  <= lik_s2;
		end
	end

	// Square root and division stages with matching delay lines.
	logic [TW-1:0]  tag_d  [0:R+E];
	logic           v_d    [0:R+E];
	logic [E+P-1:0] prod_d [0:2][0:R];
	logic [P:0]     root;
	logic [E-1:0]   quo    [0:2];

	assign tag_d[0] = {pdg_s3, mass_s3, lik_s3, en_s3, neg_s3, zero_s3};
	assign v_d[0]   = v_s3;

	for (genvar k = 0; k < R + E; k++) begin : g_delay
		always_ff @(posedge clk) begin
			if (en) tag_d[k+1] <= tag_d[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_d[k+1] <= 1'b0;
			else if (en) v_d[k+1] <= v_d[k];
		end
	end

	cppt_isqrt #(.R(R)) u_isqrt (
		.clk  (clk),
		.en   (en),
		.val  (sum_s3),
		.root (root)
	);

	for (genvar a = 0; a < 3; a++) begin : g_axis
		assign prod_d[a][0] = prod_s3[a];
		for (genvar k = 0; k < R; k++) begin : g_pd
			always_ff @(posedge clk) begin
				if (en) prod_d[a][k+1] <= prod_d[a][k];
			end
		end
		cppt_div #(.E(E), .P(P)) u_div (
			.clk (clk),
			.en  (en),
			.num (prod_d[a][R]),
			.den (root),
			.quo (quo[a])
		);
	end

	// Output register.
	logic [PDG_BITS-1:0]  t_pdg;
	logic [MASS_BITS-1:0] t_mass;
	logic [S:0]           t_lik;
	logic [E-1:0]         t_en;
	logic [2:0]           t_neg;
	logic                 t_zero;
	logic [E:0]           mom [0:2];

	assign {t_pdg, t_mass, t_lik, t_en, t_neg, t_zero} = tag_d[R+E];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (t_zero) mom[i] = '0;
			else if (t_neg[i]) mom[i] = (E+1)'(-{1'b0, quo[i]});
			else mom[i] = {1'b0, quo[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_d[R+E];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pdg_code            <= t_pdg;
			particle_mass       <= t_mass;
			likelihood          <= t_lik;
			energy_out          <= t_en;
			mom_x               <= mom[0];
			mom_y               <= mom[1];
			mom_z               <= mom[2];
			direction_undefined <= t_zero;
		end
	end

	a_photon_massless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pdg_code == CODE_PHOTON) |-> particle_mass == '0)
		else $error("photon transaction carries a nonzero mass");
	a_code_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pdg_code == CODE_PHOTON) || (pdg_code == CODE_PI0))
		else $error("unknown particle code");
	a_zero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && direction_undefined |-> (mom_x == '0) && (mom_y == '0) && (mom_z == '0))
		else $error("undefined direction with nonzero momentum");
endmodule
`default_nettype wire
